FILE: design/cmb_lock_pkg.sv
// Shared types, constants and helpers for the serial combination lock.
// No dependencies; imported by every module of the block.
`default_nettype none

package cmb_lock_pkg;

  localparam int unsigned PASS_BYTES   = 4;
  localparam int unsigned ANSWER_BYTES = 3;
  localparam int unsigned LINE_BYTES   = 9;

  localparam logic [7:0] LOCK_CHAR    = 8'h40;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  localparam logic [31:0] PASS_CODE_RST   = 32'h3132_3334;
  localparam logic [23:0] ANSWER_CODE_RST = 24'h6B_6974;
  localparam logic [3:0]  FAIL_LIMIT_RST  = 4'd3;

  localparam logic [3:0] FAIL_MAX = 4'hF;

  typedef enum logic [1:0] {
    REG_PASS_CODE   = 2'd0,
    REG_ANSWER_CODE = 2'd1,
    REG_FAIL_LIMIT  = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_UNLOCKED = 3'd1,
    EV_LOCKED   = 3'd2,
    EV_WRONG    = 3'd3,
    EV_RECOVERY = 3'd4,
    EV_PASSED   = 3'd5,
    EV_HALTED   = 3'd6,
    EV_IGNORED  = 3'd7
  } event_t;

  typedef struct packed {
    logic [31:0] pass_code;
    logic [23:0] answer_code;
    logic [3:0]  fail_limit;
  } cfg_t;

  typedef struct packed {
    logic [3:0] fail_count;
    logic       halted_flag;
    logic       in_recovery;
    logic       buzzer_on;
    logic       lock_open;
    event_t     event_code;
  } result_t;

  // byte idx of an nbytes-long code, first byte most significant
  function automatic logic [7:0] code_byte(logic [31:0] code, logic [3:0] nbytes,
                                           logic [3:0] idx);
    logic [3:0] byte_ofs;
    logic [7:0] val;
    byte_ofs = nbytes - 4'd1 - idx;
    val      = 8'h00;
    if (idx < nbytes && byte_ofs < 4'd4) begin
      unique case (byte_ofs[1:0])
        2'd0: val = code[7:0];
        2'd1: val = code[15:8];
        2'd2: val = code[23:16];
        2'd3: val = code[31:24];
        default: val = 8'h00;
      endcase
    end
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: design/cmb_lock_cfg.sv
// Configuration register file of the combination lock.
// Depends on cmb_lock_pkg for register indexes and reset values.
`default_nettype none

module cmb_lock_cfg
  import cmb_lock_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pass_code   <= PASS_CODE_RST;
      cfg_r.answer_code <= ANSWER_CODE_RST;
      cfg_r.fail_limit  <= FAIL_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_PASS_CODE:   cfg_r.pass_code   <= cfg_data;
        REG_ANSWER_CODE: cfg_r.answer_code <= cfg_data[23:0];
        REG_FAIL_LIMIT:  cfg_r.fail_limit  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: design/cmb_lock_core.sv
// Lock state and per-byte next-state logic: password groups, lock char,
// recovery lines. Depends on cmb_lock_pkg.
`default_nettype none

module cmb_lock_core
  import cmb_lock_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       item_valid,
  input  wire logic [7:0] item_byte,
  output result_t         result
);

  localparam logic [3:0] PASS_N   = 4'(PASS_BYTES);
  localparam logic [3:0] ANSWER_N = 4'(ANSWER_BYTES);
  localparam logic [3:0] LINE_N   = 4'(LINE_BYTES);

  logic [3:0] pos_r,   pos_nxt;
  logic       match_r, match_nxt;
  logic [3:0] fail_r,  fail_nxt;
  logic       open_r,  open_nxt;
  logic       recov_r, recov_nxt;
  logic       buzz_r,  buzz_nxt;
  logic       halt_r,  halt_nxt;
  event_t     ev;
  logic [3:0] pos_inc;
  logic [3:0] fail_sat;

  assign pos_inc  = pos_r + 4'd1;
  assign fail_sat = (fail_r == FAIL_MAX) ? FAIL_MAX : fail_r + 4'd1;

  always_comb begin
    pos_nxt   = pos_r;
    match_nxt = match_r;
    fail_nxt  = fail_r;
    open_nxt  = open_r;
    recov_nxt = recov_r;
    buzz_nxt  = buzz_r;
    halt_nxt  = halt_r;
    ev        = EV_NONE;
    if (halt_r) begin
      ev = EV_IGNORED;
    end else if (!recov_r) begin
      if (!open_r) begin
        if (item_byte != code_byte(cfg.pass_code, PASS_N, pos_r)) begin
          match_nxt = 1'b0;
        end
        pos_nxt = pos_inc;
        if (pos_inc >= PASS_N) begin
          if (match_nxt) begin
            open_nxt = 1'b1;
            fail_nxt = 4'd0;
            ev       = EV_UNLOCKED;
          end else begin
            fail_nxt = fail_sat;
            if (fail_sat >= cfg.fail_limit) begin
              buzz_nxt  = 1'b1;
              recov_nxt = 1'b1;
              ev        = EV_RECOVERY;
            end else begin
              ev = EV_WRONG;
            end
          end
          pos_nxt   = 4'd0;
          match_nxt = 1'b1;
        end
      end else if (item_byte == LOCK_CHAR) begin
        open_nxt = 1'b0;
        ev       = EV_LOCKED;
      end else begin
        ev = EV_IGNORED;
      end
    end else begin
      if (pos_r < ANSWER_N &&
          item_byte != code_byte({8'h00, cfg.answer_code}, ANSWER_N, pos_r)) begin
        match_nxt = 1'b0;
      end
      pos_nxt = pos_inc;
      if (item_byte == NEWLINE_CHAR || pos_inc >= LINE_N) begin
        // short line: compare missing answer bytes with zero
        for (int i = 0; i < ANSWER_BYTES; i++) begin
          if (4'(i) >= pos_inc &&
              code_byte({8'h00, cfg.answer_code}, ANSWER_N, 4'(i)) != 8'h00) begin
            match_nxt = 1'b0;
          end
        end
        if (match_nxt) begin
          fail_nxt  = 4'd0;
          recov_nxt = 1'b0;
          ev        = EV_PASSED;
        end else begin
          fail_nxt = fail_sat;
          if (fail_sat >= cfg.fail_limit) begin
            halt_nxt = 1'b1;
            ev       = EV_HALTED;
          end else begin
            ev = EV_WRONG;
          end
        end
        pos_nxt   = 4'd0;
        match_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 4'd0;
      match_r <= 1'b1;
      fail_r  <= 4'd0;
      open_r  <= 1'b0;
      recov_r <= 1'b0;
      buzz_r  <= 1'b0;
      halt_r  <= 1'b0;
    end else if (item_valid) begin
      pos_r   <= pos_nxt;
      match_r <= match_nxt;
      fail_r  <= fail_nxt;
      open_r  <= open_nxt;
      recov_r <= recov_nxt;
      buzz_r  <= buzz_nxt;
      halt_r  <= halt_nxt;
    end
  end

  assign result.event_code  = ev;
  assign result.lock_open   = open_nxt;
  assign result.buzzer_on   = buzz_nxt;
  assign result.in_recovery = recov_nxt;
  assign result.halted_flag = halt_nxt;
  assign result.fail_count  = fail_nxt;

  a_halt_in_recov: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> recov_r) else $error("halted outside recovery");
  a_open_not_recov: assert property (@(posedge clk) disable iff (!rst_n)
    !(open_r && recov_r)) else $error("open while in recovery");
  a_recov_buzz: assert property (@(posedge clk) disable iff (!rst_n)
    recov_r |-> buzz_r) else $error("recovery without buzzer");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!recov_r |-> pos_r < PASS_N) and (recov_r |-> pos_r < LINE_N))
    else $error("byte position out of range");
  a_open_clears: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(open_r) |-> fail_r == 4'd0) else $error("fail count kept on unlock");

endmodule

`default_nettype wire

FILE: design/combination_lock_with_recovery.sv
// Serial combination lock with recovery question: request stage, result stage.
// Depends on cmb_lock_pkg, cmb_lock_cfg and cmb_lock_core.
`default_nettype none

// One received byte per request, one result per request. A request is taken
// every cycle when the result side keeps up. Each byte is held in the input
// register, then its result enters the result register to be taken.
// The rate is set by the lock state update in cmb_lock_core, which finishes
// one byte per cycle while the result side keeps up. A full result register
// stalls in_tready only when the input register also holds a byte.
// The user must write configuration while idle; the block does not enforce it.

module combination_lock_with_recovery
  import cmb_lock_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [2:0] event_code, [3] lock_open,
                                       // [4] buzzer_on, [5] in_recovery,
                                       // [6] halted_flag, [10:7] fail_count
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_data
);

  cfg_t       cfg;
  result_t    result;
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  result_t    out_res_r;
  logic       advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  cmb_lock_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  cmb_lock_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (advance),
    .item_byte  (in_byte_r),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.fail_count, out_res_r.halted_flag,
                       out_res_r.in_recovery, out_res_r.buzzer_on,
                       out_res_r.lock_open, out_res_r.event_code};

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the serial combination lock with recovery question.
// Drives received bytes against a local lock predictor; depends on cmb_lock_pkg and the RTL.

module tb;
  import cmb_lock_pkg::*;

  localparam int N_PHASES    = 12;
  localparam int PHASE_ITEMS = 162;
  localparam int LAST_ITEMS  = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 5000;
  localparam int N_DIRECTED  = 22;

  typedef struct packed {
    logic [3:0] pos;
    logic       ok;
    logic [3:0] fails;
    logic       open;
    logic       buzz;
    logic       rec;
    logic       halt;
  } lock_state_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    event_t     ev;
    logic [3:0] fails;
    logic       open;
    logic       buzz;
    logic       rec;
  } byte_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [2:0] event_code, [3] lock_open, [4] buzzer_on,
                                   // [5] in_recovery, [6] halted_flag, [10:7] fail_count
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = 2'd0;
  logic [31:0] cfg_data = 32'h0;

  lock_state_t st;
  logic [31:0] pass_cfg = PASS_CODE_RST;
  logic [23:0] answer_cfg = ANSWER_CODE_RST;
  logic [3:0]  limit_cfg = FAIL_LIMIT_RST;

  result_t     pending_results [$];
  logic [7:0]  plan_q [$];
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          wrong_pct = 35;
  bit          halt_ok = 1'b0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          stuck = 0;
  int          errors = 0;
  int          n_in = 0;
  int          n_out = 0;
  int          ev_seen [8];

  byte_row_t dir_tab [0:N_DIRECTED-1] = '{
    '{8'h31, 1'b1, EV_NONE,     4'd0, 1'b0, 1'b0, 1'b0},
    '{8'h32, 1'b0, EV_NONE,     4'd0, 1'b0, 1'b0, 1'b0},
    '{8'h33, 1'b0, EV_NONE,     4'd0, 1'b0, 1'b0, 1'b0},
    '{8'h34, 1'b1, EV_UNLOCKED, 4'd0, 1'b1, 1'b0, 1'b0},
    '{8'hFF, 1'b1, EV_IGNORED,  4'd0, 1'b1, 1'b0, 1'b0},
    '{8'h40, 1'b1, EV_LOCKED,   4'd0, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, EV_NONE,     4'd0, 1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, EV_NONE,     4'd0, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, EV_NONE,     4'd0, 1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b1, EV_WRONG,    4'd1, 1'b0, 1'b0, 1'b0},
    '{8'h31, 1'b0, EV_NONE,     4'd0, 1'b0, 1'b0, 1'b0},
    '{8'h32, 1'b0, EV_NONE,     4'd0, 1'b0, 1'b0, 1'b0},
    '{8'h33, 1'b0, EV_NONE,     4'd0, 1'b0, 1'b0, 1'b0},
    '{8'h35, 1'b1, EV_WRONG,    4'd2, 1'b0, 1'b0, 1'b0},
    '{8'h39, 1'b0, EV_NONE,     4'd0, 1'b0, 1'b0, 1'b0},
    '{8'h32, 1'b0, EV_NONE,     4'd0, 1'b0, 1'b0, 1'b0},
    '{8'h33, 1'b0, EV_NONE,     4'd0, 1'b0, 1'b0, 1'b0},
    '{8'h34, 1'b1, EV_RECOVERY, 4'd3, 1'b0, 1'b1, 1'b1},
    '{8'h6B, 1'b0, EV_NONE,     4'd0, 1'b0, 1'b0, 1'b0},
    '{8'h69, 1'b0, EV_NONE,     4'd0, 1'b0, 1'b0, 1'b0},
    '{8'h74, 1'b0, EV_NONE,     4'd0, 1'b0, 1'b0, 1'b0},
    '{8'h0A, 1'b1, EV_PASSED,   4'd0, 1'b0, 1'b1, 1'b0}
  };

  combination_lock_with_recovery dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] key_byte(input logic [31:0] code, input int unsigned nbytes,
                                          input int unsigned idx);
    int unsigned sh;
    if (idx >= nbytes) return 8'h00;
    sh = 8 * (nbytes - 1 - idx);
    if (sh >= 32) return 8'h00;
    return 8'(code >> sh);
  endfunction

  function automatic logic [7:0] rand_byte_except(input logic [7:0] x);
    logic [7:0] b;
    b = 8'($urandom);
    if (b == x) b = b ^ 8'h01;
    return b;
  endfunction

  // advance the lock by one received byte and return the status it reports
  function automatic result_t lock_next(inout lock_state_t s, input logic [7:0] b);
    result_t r;
    event_t  ev;
    int      i;
    ev = EV_NONE;
    if (s.halt) begin
      ev = EV_IGNORED;
    end else if (!s.rec) begin
      if (!s.open) begin
        if (b != key_byte(pass_cfg, PASS_BYTES, s.pos)) s.ok = 1'b0;
        s.pos = s.pos + 4'd1;
        if (s.pos >= PASS_BYTES) begin
          if (s.ok) begin
            s.open  = 1'b1;
            s.fails = 4'd0;
            ev      = EV_UNLOCKED;
          end else begin
            if (s.fails < FAIL_MAX) s.fails = s.fails + 4'd1;
            if (s.fails >= limit_cfg) begin
              s.buzz = 1'b1;
              s.rec  = 1'b1;
              ev     = EV_RECOVERY;
            end else begin
              ev = EV_WRONG;
            end
          end
          s.pos = 4'd0;
          s.ok  = 1'b1;
        end
      end else if (b == LOCK_CHAR) begin
        s.open = 1'b0;
        ev     = EV_LOCKED;
      end else begin
        ev = EV_IGNORED;
      end
    end else begin
      if (s.pos < ANSWER_BYTES && b != key_byte({8'h00, answer_cfg}, ANSWER_BYTES, s.pos))
        s.ok = 1'b0;
      s.pos = s.pos + 4'd1;
      if (b == NEWLINE_CHAR || s.pos >= LINE_BYTES) begin
        for (i = s.pos; i < ANSWER_BYTES; i++)
          if (key_byte({8'h00, answer_cfg}, ANSWER_BYTES, i) != 8'h00) s.ok = 1'b0;
        if (s.ok) begin
          s.fails = 4'd0;
          s.rec   = 1'b0;
          ev      = EV_PASSED;
        end else begin
          if (s.fails < FAIL_MAX) s.fails = s.fails + 4'd1;
          if (s.fails >= limit_cfg) begin
            s.halt = 1'b1;
            ev     = EV_HALTED;
          end else begin
            ev = EV_WRONG;
          end
        end
        s.pos = 4'd0;
        s.ok  = 1'b1;
      end
    end
    r.event_code  = ev;
    r.lock_open   = s.open;
    r.buzzer_on   = s.buzz;
    r.in_recovery = s.rec;
    r.halted_flag = s.halt;
    r.fail_count  = s.fails;
    return r;
  endfunction

  // queue a full recovery line that answers correctly
  function automatic void answer_line();
    logic [7:0] b;
    int         k;
    int         n;
    for (k = 0; k < ANSWER_BYTES; k++) begin
      b = key_byte({8'h00, answer_cfg}, ANSWER_BYTES, k);
      plan_q.push_back(b);
      if (b == NEWLINE_CHAR) return;
    end
    if ($urandom_range(0, 1)) begin
      n = $urandom_range(0, LINE_BYTES - ANSWER_BYTES - 1);
      repeat (n) plan_q.push_back(rand_byte_except(NEWLINE_CHAR));
      plan_q.push_back(NEWLINE_CHAR);
    end else begin
      repeat (LINE_BYTES - ANSWER_BYTES) plan_q.push_back(rand_byte_except(NEWLINE_CHAR));
    end
  endfunction

  // plan the next group, line or lock request from the predicted lock state
  function automatic void fill_plan();
    lock_state_t sim;
    result_t     r;
    int          pick;
    int          n;
    int          k;
    int          at;
    bit          halts;
    pick   = $urandom_range(0, 99);
    plan_q = {};
    if (st.halt) begin
      plan_q.push_back(8'($urandom));
    end else if (st.rec) begin
      if (pick < wrong_pct / 2) begin
        n = $urandom_range(0, LINE_BYTES);
        for (k = 0; k < n; k++) plan_q.push_back(rand_byte_except(NEWLINE_CHAR));
        if (n < LINE_BYTES) plan_q.push_back(NEWLINE_CHAR);
      end else if (pick < wrong_pct) begin
        answer_line();
        at = $urandom_range(0, ANSWER_BYTES - 1);
        if (at < plan_q.size() && plan_q[at] != NEWLINE_CHAR) begin
          plan_q[at] = plan_q[at] ^ 8'($urandom_range(1, 255));
          if (plan_q[at] == NEWLINE_CHAR) plan_q[at] = 8'h0B;
        end
      end else begin
        answer_line();
      end
    end else if (st.open) begin
      n = $urandom_range(0, 3);
      repeat (n) plan_q.push_back(rand_byte_except(LOCK_CHAR));
      plan_q.push_back(LOCK_CHAR);
    end else if (pick < 75) begin
      for (k = st.pos; k < PASS_BYTES; k++) plan_q.push_back(key_byte(pass_cfg, PASS_BYTES, k));
      if (pick >= 45) begin
        at = $urandom_range(0, plan_q.size() - 1);
        plan_q[at] = plan_q[at] ^ 8'($urandom_range(1, 255));
      end
    end else if (pick < 92) begin
      for (k = st.pos; k < PASS_BYTES; k++) plan_q.push_back(8'($urandom));
    end else begin
      plan_q.push_back(8'($urandom));
    end
    // hold off the halt until the closing phase
    if (!halt_ok) begin
      sim   = st;
      halts = 1'b0;
      foreach (plan_q[j]) begin
        r = lock_next(sim, plan_q[j]);
        if (r.event_code == EV_HALTED) halts = 1'b1;
      end
      if (halts) begin
        plan_q = {};
        answer_line();
      end
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic typed, input result_t fixed);
    result_t p;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    p = lock_next(st, b);
    pending_results.push_back(typed ? fixed : p);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_in++;
  endtask

  task automatic load_codes(input logic [31:0] pc, input logic [23:0] ac, input logic [3:0] ma);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_PASS_CODE;
    cfg_data <= pc;
    @(posedge clk);
    cfg_addr <= REG_ANSWER_CODE;
    cfg_data <= {8'h00, ac};
    @(posedge clk);
    cfg_addr <= REG_FAIL_LIMIT;
    cfg_data <= {28'h0, ma};
    @(posedge clk);
    cfg_we     <= 1'b0;
    pass_cfg   = pc;
    answer_cfg = ac;
    limit_cfg  = ma;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    $display("tb: mismatch on %s after %0d results: got 0x%0h, want 0x%0h",
             what, n_out, got, want);
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[10:0]);
      n_out++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", out_tdata, 16'h0);
      end else begin
        want = pending_results.pop_front();
        ev_seen[want.event_code]++;
        if (got.event_code !== want.event_code)
          report_mismatch("event_code", 16'(got.event_code), 16'(want.event_code));
        if (got.lock_open !== want.lock_open)
          report_mismatch("lock_open", 16'(got.lock_open), 16'(want.lock_open));
        if (got.buzzer_on !== want.buzzer_on)
          report_mismatch("buzzer_on", 16'(got.buzzer_on), 16'(want.buzzer_on));
        if (got.in_recovery !== want.in_recovery)
          report_mismatch("in_recovery", 16'(got.in_recovery), 16'(want.in_recovery));
        if (got.halted_flag !== want.halted_flag)
          report_mismatch("halted_flag", 16'(got.halted_flag), 16'(want.halted_flag));
        if (got.fail_count !== want.fail_count)
          report_mismatch("fail_count", 16'(got.fail_count), 16'(want.fail_count));
        if (out_tdata[15:11] !== 5'h0)
          report_mismatch("tdata padding", 16'(out_tdata[15:11]), 16'h0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck <= 0;
    end else if (stuck == STUCK_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    result_t     fixed;
    logic [23:0] ac;
    logic [3:0]  ma;
    int          ph;
    int          quota;
    int          sent;
    int          k;
    st    = '0;
    st.ok = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < N_DIRECTED; k++) begin
      fixed.event_code  = dir_tab[k].ev;
      fixed.lock_open   = dir_tab[k].open;
      fixed.buzzer_on   = dir_tab[k].buzz;
      fixed.in_recovery = dir_tab[k].rec;
      fixed.halted_flag = 1'b0;
      fixed.fail_count  = dir_tab[k].fails;
      push_byte(dir_tab[k].rx, dir_tab[k].typed, fixed);
    end
    in_tvalid <= 1'b0;

    for (ph = 0; ph < N_PHASES; ph++) begin
      // drain before touching the registers
      while (pending_results.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      ac = 24'($urandom);
      for (k = 0; k < ANSWER_BYTES; k++)
        if (ac[8*k +: 8] == NEWLINE_CHAR) ac[8*k +: 8] = ac[8*k +: 8] ^ 8'h01;
      if (st.rec && st.fails < FAIL_MAX) ma = 4'($urandom_range(st.fails + 1, 15));
      else ma = 4'($urandom_range(1, 15));
      if (ph == 0) load_codes(32'h0, 24'h0, 4'd1);
      else if (ph == 1) load_codes(32'hFFFF_FFFF, 24'hFF_FFFF, 4'd15);
      else if (ph == 2) load_codes($urandom, 24'h6B_0A00, ma);
      else if (ph == N_PHASES - 1) load_codes($urandom, ac, 4'd1);
      else load_codes($urandom, ac, ma);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      halt_ok   = (ph == N_PHASES - 1);
      wrong_pct = halt_ok ? 60 : 35;
      if (ph == 3) hold_go = 1'b1;
      quota  = halt_ok ? LAST_ITEMS : PHASE_ITEMS;
      sent   = 0;
      plan_q = {};
      while (sent < quota || plan_q.size() != 0) begin
        if (plan_q.size() == 0) fill_plan();
        push_byte(plan_q.pop_front(), 1'b0, fixed);
        sent++;
      end
      in_tvalid <= 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("tb: %0d bytes in %0d phases plus a directed table, %0d results, %0d mismatches",
             n_in, N_PHASES, n_out, errors);
    $display("tb: unlock %0d, lock %0d, wrong %0d, recovery %0d, passed %0d, halt %0d, ignored %0d",
             ev_seen[EV_UNLOCKED], ev_seen[EV_LOCKED], ev_seen[EV_WRONG],
             ev_seen[EV_RECOVERY], ev_seen[EV_PASSED], ev_seen[EV_HALTED],
             ev_seen[EV_IGNORED]);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
